FILE: src/mdt_pkg.sv
`default_nettype none
package mdt_pkg;

	localparam int CH_W        = 5;
	localparam int POS_W       = 24;
	localparam int ACC_W       = 32;
	localparam int THR_W       = 23;
	localparam int CFG_DATA_W  = 23;
	localparam int CFG_IDX_W   = 1;
	localparam int NUM_CHANNELS_DEF = 32;

	localparam logic [THR_W-1:0] NEAR_RST = THR_W'(655);
	localparam logic [THR_W-1:0] FAR_RST  = THR_W'(3277);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR = 1'b0,
		CFG_FAR  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] ref_x;
		logic [POS_W-1:0] ref_y;
		logic [POS_W-1:0] ref_z;
		logic [ACC_W-1:0] acc_x;
		logic [ACC_W-1:0] acc_y;
		logic [ACC_W-1:0] acc_z;
	} mdt_entry_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             far_hit;
	} mdt_axis_res_t;

endpackage
`default_nettype wire

FILE: src/mdt_if.sv
`default_nettype none
interface mdt_in_if;
	import mdt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         channel;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, channel, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, channel, pos_x, pos_y, pos_z, output ready);
endinterface

interface mdt_out_if;
	import mdt_pkg::*;
	logic            valid;
	logic            ready;
	logic            transmit;
	logic [CH_W-1:0] out_channel;

	modport source (output valid, transmit, out_channel, input ready);
	modport sink (input valid, transmit, out_channel, output ready);
endinterface
`default_nettype wire

FILE: src/motion_deadband_trigger_core.sv
`default_nettype none
// Per-channel 3D position change trigger. Each item carries a channel and a
// signed Q8.16 x/y/z position; one result (transmit, out_channel) comes back
// for every item, in order. The block takes one item per clock while the
// output is not stalled; each item passes through the s1 register and the
// output register, and s1 holds while the output is stalled. Per-channel
// reference positions and accumulators live in one synchronous memory read
// in the accept cycle and written back when the item leaves s1; a bypass
// register covers back-to-back items on the same channel, and per-entry
// valid bits make the state read as zero right after reset, so no clearing
// pass is needed. Channels at or above NUM_CHANNELS return transmit = 0 and
// leave the state alone. The user writes thresholds through the cfg port
// only while no item is in flight; the block itself does not enforce it.
module motion_deadband_trigger_core
	import mdt_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mdt_in_if.sink                     pos_in,
	mdt_out_if.source                  res_out,
	input  wire logic                  cfg_wr_en,
	input  wire cfg_reg_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CH_EXT_W = CH_W + IDX_W;

	logic [THR_W-1:0]    near_q;
	logic [THR_W-1:0]    far_q;

	logic                accept;
	logic                in_range;
	logic [CH_EXT_W-1:0] ch_ext;
	logic [IDX_W-1:0]    in_idx;

	logic                valid_s1;
	logic                in_range_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [POS_W-1:0]    pos_x_s1;
	logic [POS_W-1:0]    pos_y_s1;
	logic [POS_W-1:0]    pos_z_s1;
	logic                adv_s1;

	mdt_entry_t          cur;
	mdt_entry_t          upd;
	mdt_axis_res_t       rx;
	mdt_axis_res_t       ry;
	mdt_axis_res_t       rz;
	logic                fire;
	logic                wr_en;

	logic                out_valid_q;
	logic                transmit_q;
	logic [CH_W-1:0]     out_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RST;
			far_q  <= FAR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NEAR: near_q <= cfg_data[THR_W-1:0];
				CFG_FAR:  far_q  <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1       = !out_valid_q || res_out.ready;
	assign pos_in.ready = !valid_s1 || adv_s1;
	assign accept       = pos_in.valid && pos_in.ready;
	assign ch_ext       = {{IDX_W{1'b0}}, pos_in.channel};
	assign in_idx       = ch_ext[IDX_W-1:0];
	assign in_range     = (32'(pos_in.channel) < NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pos_in.ready) begin
			valid_s1 <= pos_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range;
			ch_s1       <= pos_in.channel;
			idx_s1      <= in_idx;
			pos_x_s1    <= pos_in.pos_x;
			pos_y_s1    <= pos_in.pos_y;
			pos_z_s1    <= pos_in.pos_z;
		end
	end

	mdt_state_mem #(
		.DEPTH (NUM_CHANNELS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_idx  (in_idx),
		.rd_data (cur),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (upd)
	);

	mdt_axis u_axis_x (
		.pos (pos_x_s1), .ref_pos (cur.ref_x), .acc (cur.acc_x),
		.near_thr (near_q), .far_thr (far_q), .res (rx)
	);
	mdt_axis u_axis_y (
		.pos (pos_y_s1), .ref_pos (cur.ref_y), .acc (cur.acc_y),
		.near_thr (near_q), .far_thr (far_q), .res (ry)
	);
	mdt_axis u_axis_z (
		.pos (pos_z_s1), .ref_pos (cur.ref_z), .acc (cur.acc_z),
		.near_thr (near_q), .far_thr (far_q), .res (rz)
	);

	always_comb begin
		fire = in_range_s1 && (rx.far_hit || ry.far_hit || rz.far_hit);
		if (fire) begin
			upd.ref_x = pos_x_s1;
			upd.ref_y = pos_y_s1;
			upd.ref_z = pos_z_s1;
			upd.acc_x = '0;
			upd.acc_y = '0;
			upd.acc_z = '0;
		end else begin
			upd.ref_x = cur.ref_x;
			upd.ref_y = cur.ref_y;
			upd.ref_z = cur.ref_z;
			upd.acc_x = rx.acc;
			upd.acc_y = ry.acc;
			upd.acc_z = rz.acc;
		end
	end

	assign wr_en = valid_s1 && adv_s1 && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			transmit_q <= fire;
			out_ch_q   <= ch_s1;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.transmit    = transmit_q;
	assign res_out.out_channel = out_ch_q;

endmodule
`default_nettype wire

FILE: src/mdt_axis.sv
`default_nettype none
module mdt_axis
	import mdt_pkg::*;
(
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [POS_W-1:0] ref_pos,
	input  wire logic [ACC_W-1:0] acc,
	input  wire logic [THR_W-1:0] near_thr,
	input  wire logic [THR_W-1:0] far_thr,
	output mdt_axis_res_t         res
);

	localparam int D_W = POS_W + 1;
	localparam int S_W = ACC_W + 1;

	logic [D_W-1:0]   delta;
	logic [D_W-1:0]   delta_mag;
	logic [S_W-1:0]   sum;
	logic [ACC_W-1:0] sat;
	logic [ACC_W-1:0] acc_new;
	logic [ACC_W-1:0] acc_mag;

	always_comb begin
		delta     = {pos[POS_W-1], pos} - {ref_pos[POS_W-1], ref_pos};
		delta_mag = delta[D_W-1] ? (~delta + D_W'(1)) : delta;
		sum       = {{(S_W-D_W){delta[D_W-1]}}, delta} + {acc[ACC_W-1], acc};
		if (sum[S_W-1] != sum[S_W-2]) begin
			sat = sum[S_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat = sum[ACC_W-1:0];
		end
		acc_new = (delta_mag < D_W'(near_thr)) ? '0 : sat;
		acc_mag = acc_new[ACC_W-1] ? (~acc_new + ACC_W'(1)) : acc_new;
		res.acc     = acc_new;
		res.far_hit = (acc_mag >= ACC_W'(far_thr));
	end

endmodule
`default_nettype wire

FILE: src/mdt_state_mem.sv
`default_nettype none
module mdt_state_mem
	import mdt_pkg::*;
#(
	parameter int DEPTH = NUM_CHANNELS_DEF,
	parameter int IDX_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	output mdt_entry_t            rd_data,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire mdt_entry_t       wr_data
);

	mdt_entry_t       mem [DEPTH];
	mdt_entry_t       mem_rd_s1;
	logic             mem_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [DEPTH-1:0] valid_q;
	logic             last_wr_valid_q;
	logic [IDX_W-1:0] last_wr_idx_q;
	mdt_entry_t       last_wr_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_idx];
			rd_idx_s1 <= rd_idx;
		end
		if (wr_en) begin
			last_wr_idx_q  <= wr_idx;
			last_wr_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q         <= '0;
			mem_vld_s1      <= 1'b0;
			last_wr_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
				last_wr_valid_q <= 1'b1;
			end
			if (rd_en) begin
				mem_vld_s1 <= valid_q[rd_idx];
			end
		end
	end

	// forward the most recent write when it hit the index being read
	always_comb begin
		if (last_wr_valid_q && last_wr_idx_q == rd_idx_s1) begin
			rd_data = last_wr_data_q;
		end else if (mem_vld_s1) begin
			rd_data = mem_rd_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule
`default_nettype wire

FILE: src/mdt_checker.sv
`default_nettype none
module mdt_checker
	import mdt_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic [CH_W-1:0] in_channel,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic            out_transmit,
	input wire logic [CH_W-1:0] out_channel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_transmit) && $stable(out_channel))
		else $error("result changed while stalled");

	a_no_fire_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_transmit |-> 32'(out_channel) < NUM_CHANNELS)
		else $error("transmit on a channel outside the state");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2)
			&& out_channel == $past(in_channel, 2))
		else $error("result does not follow its item by two cycles");

endmodule

bind motion_deadband_trigger_core mdt_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_mdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pos_in.valid),
	.in_ready     (pos_in.ready),
	.in_channel   (pos_in.channel),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.out_transmit (res_out.transmit),
	.out_channel  (res_out.out_channel)
);
`default_nettype wire
